@@ design/cuv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cuv_pkg
// shared types and constants for the chunked upload crc verifier
// ----------------------------------------------------------------------------
package cuv_pkg;

  localparam int unsigned CANVAS_WIDTH_DEF  = 320;
  localparam int unsigned CANVAS_HEIGHT_DEF = 240;
  localparam int unsigned MAX_CHUNK_DEF     = 4096;

  localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT       = 32'hFFFFFFFF;
  localparam logic [31:0] MIN_UPLOAD     = 32'd6;
  localparam logic [31:0] CAPACITY_RESET = 32'd1048576;

  localparam int unsigned IN_TDATA_W  = 152;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 72;

  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_CHUNK  = 2'd1,
    CMD_COMMIT = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] declared_bytes;
    logic [31:0] declared_crc;
    logic [15:0] canvas_width;
    logic [15:0] canvas_height;
    logic [31:0] chunk_offset;
    logic [12:0] chunk_length;
    logic [7:0]  data_byte;
    logic        first_of_chunk;
    logic        last_of_chunk;
  } item_t;

  typedef struct packed {
    logic        status;
    logic        session_open;
    logic [31:0] received_bytes;
    logic [31:0] computed_crc;
  } result_t;

endpackage : cuv_pkg
`default_nettype wire

@@ design/cuv_crc8.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cuv_crc8
// one byte of reflected crc-32, unrolled over the eight bit steps
// ----------------------------------------------------------------------------
module cuv_crc8
  import cuv_pkg::*;
(
  input  wire logic [31:0] crc_in,
  input  wire logic [7:0]  data_byte,
  output logic      [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data_byte};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    crc_out = c;
  end

endmodule : cuv_crc8
`default_nettype wire

@@ design/cuv_session.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cuv_session
// session state, chunk acceptance, crc update and the result register
// ----------------------------------------------------------------------------
module cuv_session
  import cuv_pkg::*;
#(
  parameter int unsigned CANVAS_WIDTH  = CANVAS_WIDTH_DEF,
  parameter int unsigned CANVAS_HEIGHT = CANVAS_HEIGHT_DEF,
  parameter int unsigned MAX_CHUNK     = MAX_CHUNK_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] capacity,
  input  wire logic        in_valid,
  input  wire item_t       in_item,
  output logic             in_ready,
  output logic             out_valid,
  output result_t          out_result,
  input  wire logic        out_ready
);

  localparam logic [15:0] CanvasW  = 16'(CANVAS_WIDTH);
  localparam logic [15:0] CanvasH  = 16'(CANVAS_HEIGHT);
  localparam logic [16:0] MaxChunk = 17'(MAX_CHUNK);

  logic        active, active_next;
  logic [31:0] exp_bytes, exp_bytes_next;
  logic [31:0] exp_crc, exp_crc_next;
  logic [31:0] rx_count, rx_count_next;
  logic [31:0] run_crc, run_crc_next;
  logic        chunk_ok, chunk_ok_next;
  logic [12:0] chunk_rem, chunk_rem_next;

  logic        emits;
  logic        fire;
  result_t     res_next;
  logic [31:0] crc_byte;

  cuv_crc8 u_crc8 (
    .crc_in   (run_crc),
    .data_byte(in_item.data_byte),
    .crc_out  (crc_byte)
  );

  always_comb begin
    unique case (in_item.cmd)
      CMD_BEGIN, CMD_COMMIT: emits = 1'b1;
      CMD_CHUNK:             emits = in_item.last_of_chunk;
      default:               emits = 1'b0;
    endcase
  end

  // a result-free beat may pass even while the output register is stalled
  assign in_ready = !emits || !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    logic        ok;
    logic        acc_eff;
    logic [12:0] rem_eff;
    logic [32:0] chunk_end;

    active_next    = active;
    exp_bytes_next = exp_bytes;
    exp_crc_next   = exp_crc;
    rx_count_next  = rx_count;
    run_crc_next   = run_crc;
    chunk_ok_next  = chunk_ok;
    chunk_rem_next = chunk_rem;
    res_next       = '0;
    ok             = 1'b0;
    acc_eff        = chunk_ok;
    rem_eff        = chunk_rem;
    chunk_end      = {1'b0, rx_count} + {20'd0, in_item.chunk_length};

    unique case (in_item.cmd)
      CMD_BEGIN: begin
        ok = in_item.canvas_width == CanvasW && in_item.canvas_height == CanvasH
          && in_item.declared_bytes >= MIN_UPLOAD
          && in_item.declared_bytes <= capacity;
        if (ok) begin
          active_next    = 1'b1;
          exp_bytes_next = in_item.declared_bytes;
          exp_crc_next   = in_item.declared_crc;
          rx_count_next  = '0;
          run_crc_next   = CRC_INIT;
          chunk_ok_next  = 1'b0;
          chunk_rem_next = '0;
        end
        res_next.status         = !ok;
        res_next.session_open   = active_next;
        res_next.received_bytes = rx_count_next;
        res_next.computed_crc   = ~run_crc_next;
      end
      CMD_CHUNK: begin
        if (in_item.first_of_chunk) begin
          acc_eff = active && in_item.chunk_length != '0
            && {4'd0, in_item.chunk_length} <= MaxChunk
            && in_item.chunk_offset == rx_count
            && chunk_end <= {1'b0, exp_bytes};
          rem_eff = acc_eff ? in_item.chunk_length : '0;
        end
        if (acc_eff && active && rem_eff != '0) begin
          run_crc_next  = crc_byte;
          rx_count_next = rx_count + 32'd1;
          rem_eff       = rem_eff - 13'd1;
        end
        if (in_item.last_of_chunk) begin
          chunk_ok_next  = 1'b0;
          chunk_rem_next = '0;
        end else begin
          chunk_ok_next  = acc_eff;
          chunk_rem_next = rem_eff;
        end
        res_next.status         = !(acc_eff && active);
        res_next.session_open   = active;
        res_next.received_bytes = rx_count_next;
        res_next.computed_crc   = ~run_crc_next;
      end
      CMD_COMMIT: begin
        ok = active && in_item.declared_bytes == exp_bytes
          && in_item.declared_crc == exp_crc
          && rx_count == exp_bytes && ~run_crc == exp_crc;
        if (active) begin
          active_next    = 1'b0;
          chunk_ok_next  = 1'b0;
          chunk_rem_next = '0;
          if (!ok) begin
            exp_bytes_next = '0;
            exp_crc_next   = '0;
            rx_count_next  = '0;
            run_crc_next   = CRC_INIT;
          end
        end
        res_next.status         = !ok;
        res_next.session_open   = 1'b0;
        res_next.received_bytes = rx_count;
        res_next.computed_crc   = ~run_crc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      exp_bytes <= '0;
      exp_crc   <= '0;
      rx_count  <= '0;
      run_crc   <= CRC_INIT;
      chunk_ok  <= 1'b0;
      chunk_rem <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        active    <= active_next;
        exp_bytes <= exp_bytes_next;
        exp_crc   <= exp_crc_next;
        rx_count  <= rx_count_next;
        run_crc   <= run_crc_next;
        chunk_ok  <= chunk_ok_next;
        chunk_rem <= chunk_rem_next;
      end
      if (fire && emits) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emits) begin
      out_result <= res_next;
    end
  end

endmodule : cuv_session
`default_nettype wire

@@ design/chunked_upload_crc_verifier_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chunked_upload_crc_verifier_top
// checks a chunked upload against its declared size and crc-32
// ----------------------------------------------------------------------------
//  channel   dir  carries
//  s_axis    in   one command beat: begin, chunk data byte or commit
//  m_axis    out  one status beat per begin, commit or last chunk byte
//  cfg       in   capacity_bytes write, no read-back
//
//  a beat passes the input register, then the session logic into the result register;
//  one beat per cycle sustained unless a stalled m_axis holds a result beat;
//  the byte-wide crc update sets the path between input and result register
//  rst clears the session and both valid flags and restores the capacity default
//  a stalled m_axis holds only beats that produce a result
// ----------------------------------------------------------------------------
module chunked_upload_crc_verifier_top
  import cuv_pkg::*;
#(
  parameter int unsigned CANVAS_WIDTH  = CANVAS_WIDTH_DEF,
  parameter int unsigned CANVAS_HEIGHT = CANVAS_HEIGHT_DEF,
  parameter int unsigned MAX_CHUNK     = MAX_CHUNK_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wr_en,
  input  wire logic [31:0]            cfg_wr_data,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // declared_bytes, declared_crc, canvas_width, canvas_height, chunk_offset,
  // chunk_length, data_byte, zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd, first_of_chunk
  input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
  input  wire logic                   s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // status, session_open, received_bytes, computed_crc, zero pad
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  logic [31:0] capacity;
  logic        in_valid;
  item_t       in_item;
  logic        in_ready;
  result_t     result;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  assign s_axis_tready = !in_valid || in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.cmd            <= cmd_t'(s_axis_tuser[1:0]);
      in_item.first_of_chunk <= s_axis_tuser[2];
      in_item.last_of_chunk  <= s_axis_tlast;
      in_item.declared_bytes <= s_axis_tdata[31:0];
      in_item.declared_crc   <= s_axis_tdata[63:32];
      in_item.canvas_width   <= s_axis_tdata[79:64];
      in_item.canvas_height  <= s_axis_tdata[95:80];
      in_item.chunk_offset   <= s_axis_tdata[127:96];
      in_item.chunk_length   <= s_axis_tdata[140:128];
      in_item.data_byte      <= s_axis_tdata[148:141];
    end
  end

  cuv_session #(
    .CANVAS_WIDTH (CANVAS_WIDTH),
    .CANVAS_HEIGHT(CANVAS_HEIGHT),
    .MAX_CHUNK    (MAX_CHUNK)
  ) u_session (
    .clk       (clk),
    .rst       (rst),
    .capacity  (capacity),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_ready  (in_ready),
    .out_valid (m_axis_tvalid),
    .out_result(result),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tdata = {6'd0, result.computed_crc, result.received_bytes,
                         result.session_open, result.status};

endmodule : chunked_upload_crc_verifier_top
`default_nettype wire
